FILE: hdl/ssag_pkg.sv
// ---------------------------------------------------------------------------
// ssag_pkg
// Shared constants, register indexes, heading codes and neighbour types for
// the spiral scan address generator.
// ---------------------------------------------------------------------------
package ssag_pkg;

   // grid store dimensions
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;

   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // field widths
   localparam int NUM_W      = 7;
   localparam int START_W    = 6;
   localparam int HEAD_W     = 2;
   localparam int CELL_W     = 6;
   localparam int ORDER_W    = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   // width for bound compares: holds both the register values and the store size
   localparam int RDIM_W = $clog2(MAX_ROWS + 1);
   localparam int CDIM_W = $clog2(MAX_COLS + 1);
   localparam int DIM_RC = (RDIM_W > CDIM_W) ? RDIM_W : CDIM_W;
   localparam int DIM_W  = (DIM_RC > NUM_W) ? DIM_RC : NUM_W;

   // walk tag stored per cell
   localparam int EPOCH_W = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ROW     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COL     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_HEADING = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_CW       = 3'd5;

   // register reset values
   localparam logic [NUM_W-1:0]   RST_NUM_ROWS  = 7'd64;
   localparam logic [NUM_W-1:0]   RST_NUM_COLS  = 7'd64;
   localparam logic [START_W-1:0] RST_START_ROW = 6'd63;
   localparam logic [START_W-1:0] RST_START_COL = 6'd0;
   localparam logic [HEAD_W-1:0]  RST_START_HEAD = 2'd2;

   // heading codes
   localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd0;
   localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd1;
   localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd2;
   localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd3;

   typedef struct packed {
      logic              in_grid;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [ADDR_W-1:0] addr;
      logic [HEAD_W-1:0] dir;
   } cand_type;

   typedef struct packed {
      cand_type ahead;
      cand_type turned;
   } nbr_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
      return ADDR_W'(int'(row) * MAX_COLS + int'(col));
   endfunction

endpackage

FILE: hdl/ssag_if.sv
// ---------------------------------------------------------------------------
// ssag_if
// Request and response channels of the spiral scan address generator.
// ---------------------------------------------------------------------------
interface ssag_req_if import ssag_pkg::*; ();
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface ssag_rsp_if import ssag_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CELL_W-1:0]  cell_row;
   logic [CELL_W-1:0]  cell_col;
   logic [ORDER_W-1:0] order_number;
   logic               done_res;

   modport source (output valid, output cell_row, output cell_col,
                   output order_number, output done_res, input ready);
   modport sink   (input valid, input cell_row, input cell_col,
                   input order_number, input done_res, output ready);
endinterface

FILE: hdl/ssag_ram.sv
// ---------------------------------------------------------------------------
// ssag_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module ssag_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]                         rd_data_a,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

FILE: hdl/ssag_nbr.sv
// ---------------------------------------------------------------------------
// ssag_nbr
// Neighbour logic: the cell ahead and the cell one turn away, with their
// grid bounds check and map address.
// ---------------------------------------------------------------------------
module ssag_nbr import ssag_pkg::*; (
   input  logic [ROW_W-1:0]  pos_row,
   input  logic [COL_W-1:0]  pos_col,
   input  logic [HEAD_W-1:0] heading,
   input  logic              turn_cw,
   input  logic [NUM_W-1:0]  num_rows,
   input  logic [NUM_W-1:0]  num_cols,
   output nbr_type           nbr
);

   localparam logic signed [DIM_W:0] ONE_S = (DIM_W+1)'(1);

   logic [DIM_W-1:0]  rows_lim;
   logic [DIM_W-1:0]  cols_lim;
   logic [HEAD_W-1:0] turn_dir;

   function automatic cand_type step_cand(input logic [HEAD_W-1:0] dir,
                                          input logic [ROW_W-1:0]  prow,
                                          input logic [COL_W-1:0]  pcol,
                                          input logic [DIM_W-1:0]  rlim,
                                          input logic [DIM_W-1:0]  clim);
      logic signed [DIM_W:0] r;
      logic signed [DIM_W:0] c;
      cand_type              cand;
      r = signed'({1'b0, DIM_W'(prow)});
      c = signed'({1'b0, DIM_W'(pcol)});
      case (dir)
         HEAD_LEFT:  c = c - ONE_S;
         HEAD_UP:    r = r - ONE_S;
         HEAD_RIGHT: c = c + ONE_S;
         HEAD_DOWN:  r = r + ONE_S;
         default: ;
      endcase
      cand.in_grid = !r[DIM_W] && !c[DIM_W]
                     && (r < signed'({1'b0, rlim})) && (c < signed'({1'b0, clim}));
      cand.row  = r[ROW_W-1:0];
      cand.col  = c[COL_W-1:0];
      cand.addr = cell_addr(cand.row, cand.col);
      cand.dir  = dir;
      return cand;
   endfunction

   // bounds clipped to the store size
   assign rows_lim = (DIM_W'(num_rows) < DIM_W'(MAX_ROWS)) ? DIM_W'(num_rows) : DIM_W'(MAX_ROWS);
   assign cols_lim = (DIM_W'(num_cols) < DIM_W'(MAX_COLS)) ? DIM_W'(num_cols) : DIM_W'(MAX_COLS);

   assign turn_dir = turn_cw ? heading + HEAD_W'(1) : heading + HEAD_W'(3);

   assign nbr.ahead  = step_cand(heading, pos_row, pos_col, rows_lim, cols_lim);
   assign nbr.turned = step_cand(turn_dir, pos_row, pos_col, rows_lim, cols_lim);

endmodule

FILE: hdl/spiral_scan_address_generator.sv
// ---------------------------------------------------------------------------
// spiral_scan_address_generator
// Spiral walk over a rows-by-cols grid, one visited cell per request word.
//
//   channel   direction  contents
//   req_chan  in         restart
//   rsp_chan  out        cell_row, cell_col, order_number, done_res
//   csr_*     in         write enable, register index, write data
//
// A request word is taken in ST_READ while the map RAM reads both neighbour
// tags (registered read); ST_EVAL then decides, writes back and loads the
// response register. A register write delays the decision until the tags are read anew.
// The map holds a walk tag per cell, so a restart costs no clearing. After
// reset, and once every 255 restarts when the tag wraps, a clearing pass over
// all 4096 cells runs with req_chan not ready.
// A stalled response is held in its register while the next word is taken.
// ---------------------------------------------------------------------------
module spiral_scan_address_generator import ssag_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ssag_req_if.sink              req_chan,
   ssag_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;

   localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [ORDER_W-1:0] COUNT_MAX = {ORDER_W{1'b1}};

   // configuration registers
   logic [NUM_W-1:0]   num_rows_ff;
   logic [NUM_W-1:0]   num_cols_ff;
   logic [START_W-1:0] start_row_ff;
   logic [START_W-1:0] start_col_ff;
   logic [HEAD_W-1:0]  start_head_ff;
   logic               turn_cw_ff;

   // control and walk state
   logic [1:0]         state_ff,    state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               pend_ff,     pend_in;
   logic               restart_ff,  restart_in;
   logic [EPOCH_W-1:0] epoch_ff,    epoch_in;
   logic [ROW_W-1:0]   pos_row_ff,  pos_row_in;
   logic [COL_W-1:0]   pos_col_ff,  pos_col_in;
   logic [HEAD_W-1:0]  heading_ff,  heading_in;
   logic [ORDER_W-1:0] count_ff,    count_in;
   logic               active_ff,   active_in;
   logic               rd_ok_ff;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]  rsp_row_ff,   rsp_row_in;
   logic [CELL_W-1:0]  rsp_col_ff,   rsp_col_in;
   logic [ORDER_W-1:0] rsp_order_ff, rsp_order_in;
   logic               rsp_done_ff,  rsp_done_in;

   // map RAM
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [EPOCH_W-1:0] ram_wdata;
   logic [EPOCH_W-1:0] rd_ahead;
   logic [EPOCH_W-1:0] rd_turned;

   nbr_type            nbr;
   logic               req_fire;
   logic               out_free;
   logic               out_load;
   logic               start_inside;
   logic [ADDR_W-1:0]  start_addr;
   logic               ahead_ok;
   logic               turned_ok;

   ssag_nbr u_nbr (
      .pos_row  (pos_row_ff),
      .pos_col  (pos_col_ff),
      .heading  (heading_ff),
      .turn_cw  (turn_cw_ff),
      .num_rows (num_rows_ff),
      .num_cols (num_cols_ff),
      .nbr      (nbr)
   );

   ssag_ram #(
      .WIDTH (EPOCH_W),
      .DEPTH (DEPTH)
   ) u_map (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr_a (nbr.ahead.addr),
      .rd_data_a (rd_ahead),
      .rd_addr_b (nbr.turned.addr),
      .rd_data_b (rd_turned)
   );

   assign req_chan.ready = (state_ff == ST_READ);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign start_inside = ({1'b0, start_row_ff} < num_rows_ff)
                         && ({1'b0, start_col_ff} < num_cols_ff)
                         && (DIM_W'(start_row_ff) < DIM_W'(MAX_ROWS))
                         && (DIM_W'(start_col_ff) < DIM_W'(MAX_COLS));
   assign start_addr   = cell_addr(ROW_W'(start_row_ff), COL_W'(start_col_ff));

   // a cell is taken when it carries the tag of the current walk
   assign ahead_ok  = nbr.ahead.in_grid  && (rd_ahead  != epoch_ff);
   assign turned_ok = nbr.turned.in_grid && (rd_turned != epoch_ff);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      pend_in      = pend_ff;
      restart_in   = restart_ff;
      epoch_in     = epoch_ff;
      pos_row_in   = pos_row_ff;
      pos_col_in   = pos_col_ff;
      heading_in   = heading_ff;
      count_in     = count_ff;
      active_in    = active_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_addr_ff;
      ram_wdata    = '0;
      out_load     = 1'b0;
      rsp_done_in  = 1'b1;

      case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               clr_addr_in = '0;
               state_in    = pend_ff ? ST_EVAL : ST_READ;
            end
         end
         ST_READ: begin
            if (req_fire) begin
               restart_in = req_chan.restart;
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (restart_ff && (epoch_ff == EPOCH_MAX)) begin
               // tag space used up: wipe the map first
               epoch_in = '0;
               pend_in  = 1'b1;
               state_in = ST_CLEAR;
            end else if (out_free && (restart_ff || rd_ok_ff || !active_ff)) begin
               out_load = 1'b1;
               pend_in  = 1'b0;
               state_in = ST_READ;
               if (restart_ff) begin
                  epoch_in = epoch_ff + EPOCH_W'(1);
                  if (start_inside) begin
                     ram_we      = 1'b1;
                     ram_waddr   = start_addr;
                     ram_wdata   = epoch_ff + EPOCH_W'(1);
                     pos_row_in  = ROW_W'(start_row_ff);
                     pos_col_in  = COL_W'(start_col_ff);
                     heading_in  = start_head_ff;
                     count_in    = ORDER_W'(1);
                     active_in   = 1'b1;
                     rsp_done_in = 1'b0;
                  end else begin
                     active_in = 1'b0;
                  end
               end else if (active_ff) begin
                  if (ahead_ok || turned_ok) begin
                     ram_we      = 1'b1;
                     ram_waddr   = ahead_ok ? nbr.ahead.addr : nbr.turned.addr;
                     ram_wdata   = epoch_ff;
                     pos_row_in  = ahead_ok ? nbr.ahead.row : nbr.turned.row;
                     pos_col_in  = ahead_ok ? nbr.ahead.col : nbr.turned.col;
                     heading_in  = ahead_ok ? nbr.ahead.dir : nbr.turned.dir;
                     count_in    = (count_ff == COUNT_MAX) ? count_ff
                                                           : count_ff + ORDER_W'(1);
                     rsp_done_in = 1'b0;
                  end else begin
                     active_in = 1'b0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_READ;
         end
      endcase

      if (rsp_done_in) begin
         rsp_row_in   = '0;
         rsp_col_in   = '0;
         rsp_order_in = '0;
      end else begin
         rsp_row_in   = CELL_W'(pos_row_in);
         rsp_col_in   = CELL_W'(pos_col_in);
         rsp_order_in = count_in;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff   <= RST_NUM_ROWS;
         num_cols_ff   <= RST_NUM_COLS;
         start_row_ff  <= RST_START_ROW;
         start_col_ff  <= RST_START_COL;
         start_head_ff <= RST_START_HEAD;
         turn_cw_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_ROWS:      num_rows_ff   <= csr_wdata[NUM_W-1:0];
            CSR_NUM_COLS:      num_cols_ff   <= csr_wdata[NUM_W-1:0];
            CSR_START_ROW:     start_row_ff  <= csr_wdata[START_W-1:0];
            CSR_START_COL:     start_col_ff  <= csr_wdata[START_W-1:0];
            CSR_START_HEADING: start_head_ff <= csr_wdata[HEAD_W-1:0];
            CSR_TURN_CW:       turn_cw_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         epoch_ff     <= '0;
         pos_row_ff   <= '0;
         pos_col_ff   <= '0;
         heading_ff   <= '0;
         count_ff     <= '0;
         active_ff    <= 1'b0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         epoch_ff     <= epoch_in;
         pos_row_ff   <= pos_row_in;
         pos_col_ff   <= pos_col_in;
         heading_ff   <= heading_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         // a register write may move the turned read address: reread
         rd_ok_ff     <= !csr_we;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      restart_ff <= restart_in;
      if (out_load) begin
         rsp_row_ff   <= rsp_row_in;
         rsp_col_ff   <= rsp_col_in;
         rsp_order_ff <= rsp_order_in;
         rsp_done_ff  <= rsp_done_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.cell_row     = rsp_row_ff;
   assign rsp_chan.cell_col     = rsp_col_ff;
   assign rsp_chan.order_number = rsp_order_ff;
   assign rsp_chan.done_res     = rsp_done_ff;

endmodule

FILE: bench/spiral_scan_address_generator_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spiral_scan_address_generator_test
// Self-checking bench for the spiral scan address generator. A behavioural
// copy of the walk predicts one response word per request word; responses
// are checked field by field in order while both channels idle at random.
// ---------------------------------------------------------------------------
module spiral_scan_address_generator_test;
   import ssag_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int ORDER_SAT   = 2**ORDER_W - 1;

   typedef struct {
      logic [CELL_W-1:0]  row;
      logic [CELL_W-1:0]  col;
      logic [ORDER_W-1:0] order;
      logic               done;
   } visit_type;

   logic clock;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ssag_req_if req_chan ();
   ssag_rsp_if rsp_chan ();

   spiral_scan_address_generator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // walk registers as the block should hold them
   logic [NUM_W-1:0]   grid_rows      = RST_NUM_ROWS;
   logic [NUM_W-1:0]   grid_cols      = RST_NUM_COLS;
   logic [START_W-1:0] origin_row     = RST_START_ROW;
   logic [START_W-1:0] origin_col     = RST_START_COL;
   logic [HEAD_W-1:0]  origin_heading = RST_START_HEAD;
   logic               turn_cw        = 1'b0;

   // walk state
   bit                visited [MAX_ROWS][MAX_COLS];
   int                pos_row, pos_col, visit_count;
   logic [HEAD_W-1:0] heading;
   bit                walk_on;

   visit_type expected_visits[$];
   int        mismatches;
   bit        steady;
   int        rsp_hold;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.restart = 1'b0;
      rsp_chan.ready   = 1'b0;
      visited          = '{default: 1'b0};
      pos_row          = 0;
      pos_col          = 0;
      visit_count      = 0;
      heading          = HEAD_LEFT;
      walk_on          = 1'b0;
      mismatches       = 0;
      steady           = 1'b0;
      rsp_hold         = 0;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic bit step_to(input logic [HEAD_W-1:0] dir, input int rows_eff,
                                  input int cols_eff);
      int r, c;
      r = pos_row;
      c = pos_col;
      case (dir)
         HEAD_LEFT:  c = c - 1;
         HEAD_UP:    r = r - 1;
         HEAD_RIGHT: c = c + 1;
         HEAD_DOWN:  r = r + 1;
         default: ;
      endcase
      if (r < 0 || c < 0 || r >= rows_eff || c >= cols_eff) return 1'b0;
      if (visited[r][c]) return 1'b0;
      visited[r][c] = 1'b1;
      pos_row = r;
      pos_col = c;
      heading = dir;
      if (visit_count < ORDER_SAT) visit_count++;
      return 1'b1;
   endfunction

   // one step of the walk: the response word that a request word causes
   function automatic visit_type spiral_next(input logic restart_bit);
      visit_type         v;
      int                rows_eff, cols_eff;
      logic [HEAD_W-1:0] side;
      bit                moved;
      rows_eff = (grid_rows < MAX_ROWS) ? int'(grid_rows) : MAX_ROWS;
      cols_eff = (grid_cols < MAX_COLS) ? int'(grid_cols) : MAX_COLS;
      moved    = 1'b0;
      if (restart_bit) begin
         visited = '{default: 1'b0};
         walk_on = 1'b0;
         if (origin_row < rows_eff && origin_col < cols_eff) begin
            pos_row     = origin_row;
            pos_col     = origin_col;
            heading     = origin_heading;
            visited[pos_row][pos_col] = 1'b1;
            visit_count = 1;
            walk_on     = 1'b1;
            moved       = 1'b1;
         end
      end else if (walk_on) begin
         side  = turn_cw ? HEAD_W'(heading + 1) : HEAD_W'(heading - 1);
         moved = step_to(heading, rows_eff, cols_eff) || step_to(side, rows_eff, cols_eff);
         if (!moved) walk_on = 1'b0;
      end
      if (moved) begin
         v.row   = CELL_W'(pos_row);
         v.col   = CELL_W'(pos_col);
         v.order = ORDER_W'(visit_count);
         v.done  = 1'b0;
      end else begin
         v.row   = '0;
         v.col   = '0;
         v.order = '0;
         v.done  = 1'b1;
      end
      return v;
   endfunction

   task automatic send_word(input logic restart_bit);
      int gap;
      gap = (!steady && $urandom_range(0, 3) == 0) ? idle_len() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.restart <= restart_bit;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_visits.push_back(spiral_next(restart_bit));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_visits.size() != 0) @(posedge clock);
   endtask

   // only called with nothing in flight
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_NUM_ROWS:      grid_rows      = data;
         CSR_NUM_COLS:      grid_cols      = data;
         CSR_START_ROW:     origin_row     = data[START_W-1:0];
         CSR_START_COL:     origin_col     = data[START_W-1:0];
         CSR_START_HEADING: origin_heading = data[HEAD_W-1:0];
         CSR_TURN_CW:       turn_cw        = data[0];
         default: ;
      endcase
   endtask

   task automatic load_walk_setup(input int rows, input int cols, input int srow,
                                  input int scol, input logic [HEAD_W-1:0] dir,
                                  input logic cw);
      wait_drained();
      csr_write(CSR_NUM_ROWS, CSR_DATA_W'(rows));
      csr_write(CSR_NUM_COLS, CSR_DATA_W'(cols));
      csr_write(CSR_START_ROW, CSR_DATA_W'(srow));
      csr_write(CSR_START_COL, CSR_DATA_W'(scol));
      csr_write(CSR_START_HEADING, CSR_DATA_W'(dir));
      csr_write(CSR_TURN_CW, CSR_DATA_W'(cw));
   endtask

   // advance before any walk, then the reset setup: bottom-left corner heading right
   task automatic test_reset_setup();
      send_word(1'b0);
      send_word(1'b1);
      repeat (2) send_word(1'b0);
   endtask

   // whole 3x3 spiral clockwise, then advances past the stuck point
   task automatic test_full_spiral();
      load_walk_setup(3, 3, 0, 0, HEAD_RIGHT, 1'b1);
      send_word(1'b1);
      repeat (10) send_word(1'b0);
   endtask

   task automatic test_start_outside();
      load_walk_setup(0, 1, 0, 0, HEAD_DOWN, 1'b0);
      send_word(1'b1);
      // more rows than the store: clipped to the store height
      load_walk_setup(127, 1, 63, 0, HEAD_DOWN, 1'b0);
      send_word(1'b1);
      repeat (2) send_word(1'b0);
      wait_drained();
      csr_write(CSR_START_COL, CSR_DATA_W'(5));
      send_word(1'b1);
   endtask

   task automatic test_config_mid_walk();
      load_walk_setup(4, 4, 1, 1, HEAD_UP, 1'b0);
      send_word(1'b1);
      repeat (2) send_word(1'b0);
      wait_drained();
      csr_write(CSR_NUM_COLS, CSR_DATA_W'(1));
      send_word(1'b0);
      wait_drained();
      csr_write(CSR_TURN_CW, CSR_DATA_W'(1));
      csr_write(CSR_NUM_ROWS, CSR_DATA_W'(2));
      send_word(1'b0);
   endtask

   // response side stalls for a long stretch while requests keep coming
   task automatic test_backpressure();
      load_walk_setup(8, 8, 3, 4, HEAD_LEFT, 1'b1);
      steady   = 1'b1;
      rsp_hold = 80;
      send_word(1'b1);
      repeat (12) send_word(1'b0);
      wait_drained();
      steady   = 1'b0;
   endtask

   // enough restarts to wrap the per-cell walk tag at least once
   task automatic test_walk_tag_wrap();
      load_walk_setup(2, 2, 0, 0, HEAD_RIGHT, 1'b1);
      steady = 1'b1;
      repeat (256) send_word(1'b1);
      steady = 1'b0;
   endtask

   task automatic test_random_walks();
      int walk_items, sel, rows_v, cols_v, eff_r, eff_c, srow, scol, area, n, shift_at;
      walk_items = 0;
      while (walk_items < 240) begin
         wait_drained();
         steady = ($urandom_range(0, 4) == 0);
         sel    = $urandom_range(0, 19);
         if (sel == 0) begin
            rows_v = MAX_ROWS;
            cols_v = MAX_COLS;
         end else if (sel <= 2) begin
            rows_v = $urandom_range(0, 127);
            cols_v = $urandom_range(0, 127);
         end else begin
            rows_v = $urandom_range(1, 8);
            cols_v = $urandom_range(1, 8);
         end
         eff_r = (rows_v > MAX_ROWS) ? MAX_ROWS : rows_v;
         eff_c = (cols_v > MAX_COLS) ? MAX_COLS : cols_v;
         if (eff_r == 0 || $urandom_range(0, 9) == 0) srow = $urandom_range(0, 127);
         else srow = $urandom_range(0, eff_r - 1);
         if (eff_c == 0 || $urandom_range(0, 9) == 0) scol = $urandom_range(0, 127);
         else scol = $urandom_range(0, eff_c - 1);
         csr_write(CSR_NUM_ROWS, CSR_DATA_W'(rows_v));
         csr_write(CSR_NUM_COLS, CSR_DATA_W'(cols_v));
         csr_write(CSR_START_ROW, CSR_DATA_W'(srow));
         csr_write(CSR_START_COL, CSR_DATA_W'(scol));
         csr_write(CSR_START_HEADING, CSR_DATA_W'($urandom_range(0, 127)));
         csr_write(CSR_TURN_CW, CSR_DATA_W'($urandom_range(0, 127)));
         if ($urandom_range(0, 7) == 0)
            csr_write(CSR_IDX_W'(CSR_TURN_CW + $urandom_range(1, 2)),
                      CSR_DATA_W'($urandom_range(0, 127)));
         area = eff_r * eff_c;
         if (area > 64) n = $urandom_range(20, 150);
         else if ($urandom_range(0, 9) < 7) n = area + $urandom_range(0, 2);
         else n = $urandom_range(0, area);
         shift_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n) : -1;
         send_word(1'b1);
         for (int i = 0; i < n; i++) begin
            if (i == shift_at) begin
               wait_drained();
               case ($urandom_range(0, 2))
                  0: csr_write(CSR_NUM_ROWS, CSR_DATA_W'($urandom_range(1, 8)));
                  1: csr_write(CSR_NUM_COLS, CSR_DATA_W'($urandom_range(1, 8)));
                  default: csr_write(CSR_TURN_CW, CSR_DATA_W'($urandom_range(0, 1)));
               endcase
            end
            // the odd restart breaks a walk off early
            send_word($urandom_range(0, 19) == 0);
         end
         walk_items += n + 1;
      end
      steady = 1'b0;
   endtask

   // response side: random stalls, or a counted hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (rsp_hold) @(negedge clock);
            rsp_hold = 0;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (idle_len() - 1) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      visit_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (expected_visits.size() == 0) begin
               $error("unexpected response word: row %0d col %0d order %0d done %0b",
                      rsp_chan.cell_row, rsp_chan.cell_col, rsp_chan.order_number,
                      rsp_chan.done_res);
               mismatches++;
            end else begin
               want = expected_visits.pop_front();
               if (rsp_chan.cell_row !== want.row) begin
                  $error("cell_row: expected %0d, got %0d", want.row, rsp_chan.cell_row);
                  mismatches++;
               end
               if (rsp_chan.cell_col !== want.col) begin
                  $error("cell_col: expected %0d, got %0d", want.col, rsp_chan.cell_col);
                  mismatches++;
               end
               if (rsp_chan.order_number !== want.order) begin
                  $error("order_number: expected %0d, got %0d", want.order,
                         rsp_chan.order_number);
                  mismatches++;
               end
               if (rsp_chan.done_res !== want.done) begin
                  $error("done_res: expected %0b, got %0b", want.done, rsp_chan.done_res);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_setup();
      test_full_spiral();
      test_start_outside();
      test_config_mid_walk();
      test_backpressure();
      test_walk_tag_wrap();
      test_random_walks();
      wait_drained();
      repeat (16) @(posedge clock);
      if (expected_visits.size() != 0) begin
         $error("%0d response words never arrived", expected_visits.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/ssag_pkg.sv
hdl/ssag_if.sv
hdl/ssag_ram.sv
hdl/ssag_nbr.sv
hdl/spiral_scan_address_generator.sv
bench/spiral_scan_address_generator_test.sv
